>>> src/bba_pkg.sv
package bba_pkg;

    // operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_COUNT = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_BSIZE = 2'd1;
    localparam logic [1:0] REG_BYTES = 2'd2;

    localparam int PADDR_W = 4;

    localparam logic [30:0] BASE_RESET  = 31'd0;
    localparam logic [16:0] BSIZE_RESET = 17'd1024;
    localparam logic [7:0]  BYTES_RESET = 8'd128;
    localparam logic [30:0] ADDR_MAX    = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] byte_index;
        logic [7:0] byte_value;
    } request_t;

    typedef struct packed {
        logic        found;
        logic [9:0]  block_index;
        logic [2:0]  bit_in_byte;
        logic [6:0]  found_byte;
        logic [7:0]  updated_byte;
        logic [30:0] block_address;
        logic [10:0] free_count;
    } result_t;

    typedef struct packed {
        logic clear_en;
        logic start_scan;
        logic scan_en;
        logic take_hit;
        logic mul_en;
        logic wr_byte;
        logic fin_alloc;
        logic fin_count;
        logic fin_zero;
    } ctl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hit;
        logic scan_end;
    } ctl_sts_t;

endpackage

>>> src/bba_ram.sv
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/bba_ctrl.sv
module bba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         opcode,
    input  bba_pkg::ctl_sts_t  sts,
    output logic               busy,
    output bba_pkg::ctl_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       alloc_mode_reg, alloc_mode_next;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next      = state_reg;
        alloc_mode_next = alloc_mode_reg;
        cmd             = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        bba_pkg::OP_ALLOC:
                        begin
                            alloc_mode_next = 1'b1;
                            cmd.start_scan  = 1'b1;
                            state_next      = ST_SCAN;
                        end
                        bba_pkg::OP_COUNT:
                        begin
                            alloc_mode_next = 1'b0;
                            cmd.start_scan  = 1'b1;
                            state_next      = ST_SCAN;
                        end
                        bba_pkg::OP_WRITE:
                        begin
                            cmd.wr_byte  = 1'b1;
                            cmd.fin_zero = 1'b1;
                        end
                        default:
                        begin
                            cmd.fin_zero = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (alloc_mode_reg && sts.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = ST_MUL;
                end
                else if (sts.scan_end)
                begin
                    cmd.fin_zero  = alloc_mode_reg;
                    cmd.fin_count = !alloc_mode_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.fin_alloc = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            alloc_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            alloc_mode_reg <= alloc_mode_next;
        end
    end

`ifndef SYNTHESIS
    a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.fin_alloc, cmd.fin_count, cmd.fin_zero, cmd.take_hit}))
        else $error("more than one finishing command at once");

    a_hit_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_hit |=> cmd.mul_en ##1 cmd.fin_alloc)
        else $error("allocate hit did not run through address computation");
`endif

endmodule

>>> src/bba_datapath.sv
module bba_datapath #(
    parameter int BITMAP_BYTES = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bba_pkg::request_t  request,
    input  bba_pkg::ctl_cmd_t  cmd,
    input  logic [30:0]        data_base_address,
    input  logic [16:0]        block_size,
    input  logic [7:0]         bitmap_bytes_in_use,
    output bba_pkg::ctl_sts_t  sts,
    output logic               done,
    output bba_pkg::result_t   result
);

    localparam int AW   = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int SW   = AW + 1;
    localparam int IW   = AW + 3;
    localparam int PW   = IW + 17;
    localparam int SUMW = ((PW > 31) ? PW : 31) + 1;
    localparam int CW   = $clog2(8 * BITMAP_BYTES + 1);

    function automatic logic [2:0] first_clear(input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!b[k])
            begin
                pos = 3'(k);
            end
        end
        return pos;
    endfunction

    function automatic logic [3:0] count_clear(input logic [7:0] b);
        logic [3:0] c;
        c = 4'd0;
        for (int k = 0; k < 8; k++)
        begin
            c = c + {3'b000, ~b[k]};
        end
        return c;
    endfunction

    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [SW-1:0]     scan_cnt_reg, scan_cnt_next;
    logic [SW-1:0]     limit_reg, limit_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     acc_reg, acc_next;
    logic [AW-1:0]     hit_byte_reg, hit_byte_next;
    logic [2:0]        hit_bit_reg, hit_bit_next;
    logic [7:0]        hit_nb_reg, hit_nb_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic              done_reg, done_next;
    bba_pkg::result_t  result_reg, result_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    logic              issue;
    logic              wr_in_range;
    logic [2:0]        rd_bit;
    logic [7:0]        rd_nb;
    logic [SW-1:0]     limit_now;
    logic [SUMW-1:0]   addr_sum;
    logic [30:0]       addr_sat;
    logic [IW-1:0]     hit_idx;

    assign limit_now   = (32'(bitmap_bytes_in_use) > 32'(BITMAP_BYTES)) ?
                         SW'(BITMAP_BYTES) : SW'(bitmap_bytes_in_use);
    assign wr_in_range = 32'(request.byte_index) < 32'(BITMAP_BYTES);
    assign issue       = cmd.scan_en && (scan_cnt_reg < limit_reg);
    assign rd_bit      = first_clear(ram_rdata);
    assign rd_nb       = ram_rdata | (8'd1 << rd_bit);
    assign hit_idx     = {hit_byte_reg, hit_bit_reg};
    assign addr_sum    = SUMW'(data_base_address) + SUMW'(prod_reg);
    assign addr_sat    = (addr_sum > SUMW'(bba_pkg::ADDR_MAX)) ? bba_pkg::ADDR_MAX
                                                              : addr_sum[30:0];

    assign sts.clr_last = (clr_cnt_reg == AW'(BITMAP_BYTES - 1));
    assign sts.hit      = rd_vld_reg && (ram_rdata != 8'hFF);
    assign sts.scan_end = !rd_vld_reg && (scan_cnt_reg >= limit_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (cmd.clear_en)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else if (cmd.take_hit)
        begin
            ram_we    = 1'b1;
            ram_waddr = rd_idx_reg;
            ram_wdata = rd_nb;
        end
        else if (cmd.wr_byte && wr_in_range)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(request.byte_index);
            ram_wdata = request.byte_value;
        end
    end

    bba_ram #(
        .WIDTH (8),
        .DEPTH (BITMAP_BYTES)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        scan_cnt_next = scan_cnt_reg;
        limit_next    = limit_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        acc_next      = acc_reg;
        hit_byte_next = hit_byte_reg;
        hit_bit_next  = hit_bit_reg;
        hit_nb_next   = hit_nb_reg;
        prod_next     = prod_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        if (cmd.clear_en)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end

        if (cmd.start_scan)
        begin
            scan_cnt_next = '0;
            limit_next    = limit_now;
            acc_next      = '0;
        end
        else if (cmd.scan_en)
        begin
            // reads run one ahead; a late read after a hit is just dropped
            if (issue)
            begin
                rd_vld_next   = 1'b1;
                rd_idx_next   = scan_cnt_reg[AW-1:0];
                scan_cnt_next = scan_cnt_reg + SW'(1);
            end
            if (rd_vld_reg)
            begin
                acc_next = acc_reg + CW'(count_clear(ram_rdata));
            end
        end

        if (cmd.take_hit)
        begin
            hit_byte_next = rd_idx_reg;
            hit_bit_next  = rd_bit;
            hit_nb_next   = rd_nb;
        end

        if (cmd.mul_en)
        begin
            prod_next = PW'(hit_idx) * PW'(block_size);
        end

        if (cmd.fin_zero)
        begin
            done_next   = 1'b1;
            result_next = '0;
        end
        else if (cmd.fin_count)
        begin
            done_next              = 1'b1;
            result_next            = '0;
            result_next.free_count = 11'(acc_reg);
        end
        else if (cmd.fin_alloc)
        begin
            done_next                 = 1'b1;
            result_next.found         = 1'b1;
            result_next.block_index   = 10'(hit_idx);
            result_next.bit_in_byte   = hit_bit_reg;
            result_next.found_byte    = 7'(hit_byte_reg);
            result_next.updated_byte  = hit_nb_reg;
            result_next.block_address = addr_sat;
            result_next.free_count    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            scan_cnt_reg <= '0;
            limit_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            scan_cnt_reg <= scan_cnt_next;
            limit_reg    <= limit_next;
            rd_vld_reg   <= rd_vld_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        acc_reg      <= acc_next;
        hit_byte_reg <= hit_byte_next;
        hit_bit_reg  <= hit_bit_next;
        hit_nb_reg   <= hit_nb_next;
        prod_reg     <= prod_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_hit_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_hit |-> rd_vld_reg && (ram_rdata != 8'hFF))
        else $error("hit taken without a valid non-full byte");

    a_found_bit_set: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.found |->
            result_reg.updated_byte[result_reg.bit_in_byte] &&
            (result_reg.block_index[2:0] == result_reg.bit_in_byte))
        else $error("reported block bit is not set in the updated byte");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !result_reg.found |->
            (result_reg.block_address == '0) && (result_reg.updated_byte == '0))
        else $error("result without a block carries allocation fields");
`endif

endmodule

>>> src/bitmap_block_allocator_core.sv
// First-fit block allocator over a usage bitmap held in a 1R1W RAM.
// Allocate/count: one bitmap byte read per cycle while scanning, at most min(bytes-in-use,
// BITMAP_BYTES) bytes; allocate stops at the first non-full byte, then multiplies and adds.
// Write and no-op items: result strobe the cycle after start; busy stays low.
// One item at a time (busy high while scanning or computing the address); done pulses one cycle, receiver never stalls.
// After reset a clearing pass zeroes the RAM, one byte a cycle; busy stays high until every byte is cleared.
module bitmap_block_allocator_core #(
    parameter int BITMAP_BYTES = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  bba_pkg::request_t            request,
    output logic                         done,
    output bba_pkg::result_t             result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [30:0]        base_reg, base_next;
    logic [16:0]        bsize_reg, bsize_next;
    logic [7:0]         bytes_reg, bytes_next;
    logic               cfg_wr;
    bba_pkg::ctl_cmd_t  cmd;
    bba_pkg::ctl_sts_t  sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        base_next  = base_reg;
        bsize_next = bsize_reg;
        bytes_next = bytes_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                bba_pkg::REG_BASE:  base_next  = pwdata[30:0];
                bba_pkg::REG_BSIZE: bsize_next = pwdata[16:0];
                bba_pkg::REG_BYTES: bytes_next = pwdata[7:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            bba_pkg::REG_BASE:  prdata = {1'b0, base_reg};
            bba_pkg::REG_BSIZE: prdata = {15'd0, bsize_reg};
            bba_pkg::REG_BYTES: prdata = {24'd0, bytes_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= bba_pkg::BASE_RESET;
            bsize_reg <= bba_pkg::BSIZE_RESET;
            bytes_reg <= bba_pkg::BYTES_RESET;
        end
        else
        begin
            base_reg  <= base_next;
            bsize_reg <= bsize_next;
            bytes_reg <= bytes_next;
        end
    end

    bba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (request.opcode),
        .sts    (sts),
        .busy   (busy),
        .cmd    (cmd)
    );

    bba_datapath #(
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .request             (request),
        .cmd                 (cmd),
        .data_base_address   (base_reg),
        .block_size          (bsize_reg),
        .bitmap_bytes_in_use (bytes_reg),
        .sts                 (sts),
        .done                (done),
        .result              (result)
    );

endmodule
